// ===== src/lpht_pkg.sv =====
// ============================================================================
// lpht_pkg - shared types and constants for the linear probe hash table
// Slot layout, operation and status codes, and the RAM request/response
// structs passed between the probe controller and the slot RAM.
// ============================================================================
package lpht_pkg;

    // Table size; must be a power of two (home slot is the low hash bits)
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MAX_W    = 9;
    localparam int CMP_W    = (CNT_W > MAX_W) ? CNT_W : MAX_W;

    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 64;

    localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = MAX_W'(192);

    // Slot states
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // Operations
    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]       state;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_entry_t      wr_data;
        logic             clear;
    } ram_req_t;

    typedef struct packed {
        logic        valid;
        slot_entry_t entry;
    } ram_rsp_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value;
    } result_t;

endpackage

// ===== src/lpht_slot_ram.sv =====
// ============================================================================
// lpht_slot_ram - slot store
// One-port-read, one-port-write synchronous RAM holding state, key and value
// per slot, with a per-slot valid flop so reset and clear empty it at once.
// ============================================================================
module lpht_slot_ram (
    input  logic                clk,
    input  logic                rst_n,
    input  lpht_pkg::ram_req_t  req,
    output lpht_pkg::ram_rsp_t  rsp
);

    lpht_pkg::slot_entry_t              mem [lpht_pkg::CAPACITY];
    logic [lpht_pkg::CAPACITY-1:0]      valid_reg;
    lpht_pkg::slot_entry_t              rd_data_reg;
    logic                               rd_valid_reg;

    // Data array: no reset, read data held between reads
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Valid flops: unwritten slot reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.entry = rd_data_reg;

endmodule

// ===== src/lpht_probe_ctrl.sv =====
// ============================================================================
// lpht_probe_ctrl - probe sequencer
// Walks slots one RAM read per cycle, then resolves the request with one
// write-back at most, tracks occupancy and holds the max_entries register.
// ============================================================================
module lpht_probe_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [lpht_pkg::KEY_W-1:0]         key_id,
    input  logic [lpht_pkg::HASH_W-1:0]        key_hash,
    input  logic [lpht_pkg::VAL_W-1:0]         value_in,
    input  logic                               cfg_write_en,
    input  logic [lpht_pkg::MAX_W-1:0]         cfg_write_data,
    output lpht_pkg::ram_req_t                 ram_req,
    input  lpht_pkg::ram_rsp_t                 ram_rsp,
    output logic                               res_valid,
    input  logic                               res_ready,
    output lpht_pkg::result_t                  res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    localparam logic [lpht_pkg::IDX_W-1:0] LAST_PROBE =
        lpht_pkg::IDX_W'(lpht_pkg::CAPACITY - 1);

    logic [1:0]                    state_reg,      state_next;
    logic [1:0]                    op_reg,         op_next;
    logic [lpht_pkg::KEY_W-1:0]    key_reg,        key_next;
    logic [lpht_pkg::VAL_W-1:0]    val_reg,        val_next;
    logic [lpht_pkg::IDX_W-1:0]    idx_reg,        idx_next;
    logic [lpht_pkg::IDX_W-1:0]    cnt_reg,        cnt_next;
    logic                          tomb_found_reg, tomb_found_next;
    logic [lpht_pkg::IDX_W-1:0]    tomb_idx_reg,   tomb_idx_next;
    logic [lpht_pkg::CNT_W-1:0]    occ_reg,        occ_next;
    logic [lpht_pkg::MAX_W-1:0]    max_reg,        max_next;
    lpht_pkg::result_t             res_reg,        res_next;

    logic [1:0]                    slot_st;
    logic                          is_empty;
    logic                          is_hit;
    logic                          is_tomb;
    logic                          tomb_avail;
    logic [lpht_pkg::IDX_W-1:0]    tomb_at;
    logic                          at_limit;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        slot_st    = ram_rsp.valid ? ram_rsp.entry.state : lpht_pkg::SLOT_EMPTY;
        is_empty   = (slot_st == lpht_pkg::SLOT_EMPTY);
        is_hit     = (slot_st == lpht_pkg::SLOT_LIVE) && (ram_rsp.entry.key == key_reg);
        is_tomb    = !is_empty && (slot_st != lpht_pkg::SLOT_LIVE);
        tomb_avail = tomb_found_reg || is_tomb;
        tomb_at    = tomb_found_reg ? tomb_idx_reg : idx_reg;
        at_limit   = (lpht_pkg::CMP_W'(occ_reg) >= lpht_pkg::CMP_W'(max_reg));
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        tomb_found_next = tomb_found_reg;
        tomb_idx_next   = tomb_idx_reg;
        occ_next        = occ_reg;
        max_next        = cfg_write_en ? cfg_write_data : max_reg;
        res_next        = res_reg;
        ram_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    key_next = key_id;
                    val_next = value_in;
                    if (operation == lpht_pkg::OP_CLEAR)
                    begin
                        ram_req.clear = 1'b1;
                        occ_next      = '0;
                        res_next      = '{status: lpht_pkg::ST_OK, value: '0};
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = key_hash[lpht_pkg::IDX_W-1:0];
                        idx_next        = key_hash[lpht_pkg::IDX_W-1:0];
                        cnt_next        = '0;
                        tomb_found_next = 1'b0;
                        state_next      = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (is_empty || is_hit || (cnt_reg == LAST_PROBE))
                begin
                    res_next   = '{status: lpht_pkg::ST_OK, value: '0};
                    state_next = S_DONE;
                    case (op_reg)
                        lpht_pkg::OP_GET:
                        begin
                            if (is_hit)
                                res_next.value = ram_rsp.entry.value;
                            else
                                res_next.status = lpht_pkg::ST_MISSING;
                        end
                        lpht_pkg::OP_SET:
                        begin
                            if (is_hit)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = idx_reg;
                                ram_req.wr_data = '{state: lpht_pkg::SLOT_LIVE,
                                                    key: key_reg, value: val_reg};
                            end
                            else if (at_limit)
                            begin
                                res_next.status = lpht_pkg::ST_FULL;
                            end
                            else if (tomb_avail)
                            begin
                                // reuse first tombstone, occupancy unchanged
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = tomb_at;
                                ram_req.wr_data = '{state: lpht_pkg::SLOT_LIVE,
                                                    key: key_reg, value: val_reg};
                            end
                            else if (is_empty)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = idx_reg;
                                ram_req.wr_data = '{state: lpht_pkg::SLOT_LIVE,
                                                    key: key_reg, value: val_reg};
                                occ_next        = occ_reg + lpht_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                res_next.status = lpht_pkg::ST_FULL;
                            end
                        end
                        lpht_pkg::OP_REMOVE:
                        begin
                            if (is_hit)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = idx_reg;
                                ram_req.wr_data = '{state: lpht_pkg::SLOT_TOMB,
                                                    key: ram_rsp.entry.key,
                                                    value: ram_rsp.entry.value};
                            end
                            else
                            begin
                                res_next.status = lpht_pkg::ST_MISSING;
                            end
                        end
                        default:
                        begin
                            res_next.status = lpht_pkg::ST_OK;
                        end
                    endcase
                end
                else
                begin
                    if (is_tomb && !tomb_found_reg)
                    begin
                        tomb_found_next = 1'b1;
                        tomb_idx_next   = idx_reg;
                    end
                    idx_next        = idx_reg + lpht_pkg::IDX_W'(1);
                    cnt_next        = cnt_reg + lpht_pkg::IDX_W'(1);
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = idx_reg + lpht_pkg::IDX_W'(1);
                end
            end

            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            max_reg   <= lpht_pkg::MAX_ENTRIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        tomb_found_reg <= tomb_found_next;
        tomb_idx_reg   <= tomb_idx_next;
        res_reg        <= res_next;
    end

endmodule

// ===== src/linear_probe_hash_table.sv =====
// ============================================================================
// linear_probe_hash_table - open-addressing table, linear probing, tombstones
// Probing: one slot is probed per RAM read; a clear does no probe walk.
// Requests: a new request is accepted only once the previous result has been
//   handed from the controller to the output register.
// Reset: table empty at once via per-slot valid flops, occupancy 0,
//   max_entries 192; no clearing pass.
// ============================================================================
module linear_probe_hash_table (
    input  logic                         clk,
    input  logic                         rst_n,

    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [lpht_pkg::KEY_W-1:0]   key_id,
    input  logic [lpht_pkg::HASH_W-1:0]  key_hash,
    input  logic [lpht_pkg::VAL_W-1:0]   value_in,

    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [lpht_pkg::VAL_W-1:0]   value_out,

    // max_entries register
    input  logic                         cfg_write_en,
    input  logic [lpht_pkg::MAX_W-1:0]   cfg_write_data
);

    lpht_pkg::ram_req_t  ram_req;
    lpht_pkg::ram_rsp_t  ram_rsp;
    lpht_pkg::result_t   res;
    logic                res_valid;
    logic                res_ready;

    logic                          out_valid_reg;
    logic [1:0]                    status_reg;
    logic [lpht_pkg::VAL_W-1:0]    value_out_reg;

    // Slot store: state, key and value per slot
    lpht_slot_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rsp   (ram_rsp)
    );

    // Probe walk, write-back, occupancy and limit register
    lpht_probe_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .key_id         (key_id),
        .key_hash       (key_hash),
        .value_in       (value_in),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .ram_req        (ram_req),
        .ram_rsp        (ram_rsp),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // Output register: the controller hands over when it is empty or
    // being drained in the same cycle; a result held in the controller
    // stalls the next request's acceptance until it is handed over.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload only; no reset needed
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            status_reg    <= res.status;
            value_out_reg <= res.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

endmodule
